// ----- hdl/pq_pkg.sv -----
package pq_pkg;

  // Default sizes of the queue.
  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_KEY_WIDTH = 32;

  // Fixed field widths of the channels.
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes.
  localparam logic REG_MIN_MODE = 1'b0;

  // Reset value of the order select.
  localparam logic MIN_MODE_RESET = 1'b1;

  // Request codes.
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_EXT_RD,
    S_EXT_LD,
    S_HEAP_RD,
    S_HEAP_LD,
    S_DOWN_ISSUE,
    S_DOWN_EVAL,
    S_UP_ISSUE,
    S_UP_EVAL,
    S_DONE
  } pq_state_t;

endpackage

// ----- hdl/pq_req_if.sv -----
interface pq_req_if
  import pq_pkg::*;
#(
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic [CMD_W-1:0]            cmd;
  logic signed [KEY_WIDTH-1:0] key_in;

  modport source (output valid, output cmd, output key_in, input ready);
  modport sink   (input valid, input cmd, input key_in, output ready);
endinterface

// ----- hdl/pq_rsp_if.sv -----
interface pq_rsp_if
  import pq_pkg::*;
#(
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] key_out;
  logic [STATUS_W-1:0]         status;
  logic [COUNT_W-1:0]          count;

  modport source (output valid, output key_out, output status, output count, input ready);
  modport sink   (input valid, input key_out, input status, input count, output ready);
endinterface

// ----- hdl/pq_cfg.sv -----
module pq_cfg
  import pq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  min_mode
);

  logic wr_sel;

  // The port never inserts wait states.
  assign pready = 1'b1;

  // Register index is the word address.
  assign wr_sel = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_MODE);

  // Order select register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_mode <= MIN_MODE_RESET;
    end else if (wr_sel) begin
      min_mode <= pwdata[0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIN_MODE) begin
      prdata[0] = min_mode;
    end
  end

endmodule

// ----- hdl/pq_key_ram.sv -----
module pq_key_ram
  import pq_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
)(
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  logic [KEY_WIDTH-1:0]        wr_data,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr_a,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr_b,
  output logic [KEY_WIDTH-1:0]        rd_data_a,
  output logic [KEY_WIDTH-1:0]        rd_data_b
);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- hdl/pq_ctrl.sv -----
module pq_ctrl
  import pq_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
)(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        min_mode,
  pq_req_if.sink                      req,
  pq_rsp_if.source                    rsp,
  output logic                        wr_en,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  output logic [KEY_WIDTH-1:0]        wr_data,
  output logic [$clog2(CAPACITY)-1:0] rd_addr_a,
  output logic [$clog2(CAPACITY)-1:0] rd_addr_b,
  input  logic [KEY_WIDTH-1:0]        rd_data_a,
  input  logic [KEY_WIDTH-1:0]        rd_data_b
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = IDX_W + 2;

  pq_state_t state, state_next;

  // Control registers.
  logic [CNT_W-1:0] cnt;
  logic             heap_mode;
  logic             rebuilding;

  // Working registers.
  logic [CMD_W-1:0]     cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] k;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     hj;
  logic [CNT_W-1:0]     lim;
  logic [KEY_WIDTH-1:0] res_key;
  logic [STATUS_W-1:0]  res_status;

  // Derived values.
  logic [CW-1:0]        l_w, r_w;
  logic [IDX_W-1:0]     idx_m1, parent;
  logic                 leaf, r_ok, c_right, child_wins, key_wins;
  logic [KEY_WIDTH-1:0] dc;
  logic [IDX_W-1:0]     c_idx;
  logic                 mode_stale, full, down_done, rsp_load;
  logic [IDX_W-1:0]     hj_start;

  // True when key a leaves the queue before key b in the current order.
  function automatic logic better(input logic mm, input logic [KEY_WIDTH-1:0] a,
                                  input logic [KEY_WIDTH-1:0] b);
    if (mm) begin
      return $signed(a) < $signed(b);
    end
    return $signed(a) > $signed(b);
  endfunction

  // Heap index arithmetic.
  assign l_w        = {1'b0, idx, 1'b1};
  assign r_w        = l_w + CW'(1);
  assign idx_m1     = idx - IDX_W'(1);
  assign parent     = idx_m1 >> 1;
  assign leaf       = l_w >= CW'(lim);
  assign r_ok       = r_w < CW'(lim);
  assign c_right    = r_ok && better(min_mode, rd_data_b, rd_data_a);
  assign dc         = c_right ? rd_data_b : rd_data_a;
  assign c_idx      = c_right ? r_w[IDX_W-1:0] : l_w[IDX_W-1:0];
  assign child_wins = better(min_mode, dc, k);
  assign key_wins   = better(min_mode, k, rd_data_a);

  assign mode_stale = heap_mode != min_mode;
  assign full       = cnt >= CNT_W'(CAPACITY);
  assign hj_start   = IDX_W'((cnt >> 1) - CNT_W'(1));
  assign down_done  = ((state == S_DOWN_ISSUE) && leaf) ||
                      ((state == S_DOWN_EVAL) && !child_wins);
  assign rsp_load   = (state == S_DONE) && (!rsp.valid || rsp.ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_r == CMD_CLEAR) begin
          state_next = S_DONE;
        end else if (cmd_r != CMD_INSERT && cmd_r != CMD_EXTRACT) begin
          state_next = S_DONE;
        end else if (mode_stale) begin
          state_next = (cnt > CNT_W'(1)) ? S_HEAP_RD : S_CHECK;
        end else if (cmd_r == CMD_INSERT) begin
          state_next = full ? S_DONE : S_UP_ISSUE;
        end else begin
          state_next = (cnt == '0) ? S_DONE : S_EXT_RD;
        end
      end
      S_EXT_RD:  state_next = S_EXT_LD;
      S_EXT_LD:  state_next = (cnt == CNT_W'(1)) ? S_DONE : S_DOWN_ISSUE;
      S_HEAP_RD: state_next = S_HEAP_LD;
      S_HEAP_LD: state_next = S_DOWN_ISSUE;
      S_DOWN_ISSUE, S_DOWN_EVAL: begin
        if (down_done) begin
          if (!rebuilding) begin
            state_next = S_DONE;
          end else if (hj == '0) begin
            state_next = S_CHECK;
          end else begin
            state_next = S_HEAP_RD;
          end
        end else if (state == S_DOWN_ISSUE) begin
          state_next = S_DOWN_EVAL;
        end else begin
          state_next = S_DOWN_ISSUE;
        end
      end
      S_UP_ISSUE: state_next = (idx == '0) ? S_DONE : S_UP_EVAL;
      S_UP_EVAL:  state_next = key_wins ? S_UP_ISSUE : S_DONE;
      S_DONE: begin
        if (rsp_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    req.ready = (state == S_IDLE);
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_data   = k;
    rd_addr_a = l_w[IDX_W-1:0];
    rd_addr_b = r_w[IDX_W-1:0];
    unique case (state)
      S_EXT_RD: begin
        rd_addr_a = '0;
        rd_addr_b = IDX_W'(cnt - CNT_W'(1));
      end
      S_HEAP_RD: rd_addr_a = hj;
      S_DOWN_ISSUE: wr_en = leaf;
      S_DOWN_EVAL: begin
        wr_en = 1'b1;
        if (child_wins) wr_data = dc;
      end
      S_UP_ISSUE: begin
        rd_addr_a = parent;
        wr_en     = (idx == '0);
      end
      S_UP_EVAL: begin
        wr_en = 1'b1;
        if (key_wins) wr_data = rd_data_a;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      heap_mode  <= MIN_MODE_RESET;
      rebuilding <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CHECK: begin
          if (cmd_r == CMD_CLEAR) begin
            cnt       <= '0;
            heap_mode <= min_mode;
          end else if (cmd_r == CMD_INSERT || cmd_r == CMD_EXTRACT) begin
            if (mode_stale) begin
              if (cnt > CNT_W'(1)) begin
                rebuilding <= 1'b1;
              end else begin
                heap_mode <= min_mode;
              end
            end else if (cmd_r == CMD_INSERT && !full) begin
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        S_EXT_LD: cnt <= cnt - CNT_W'(1);
        S_DOWN_ISSUE, S_DOWN_EVAL: begin
          if (down_done && rebuilding && hj == '0) begin
            rebuilding <= 1'b0;
            heap_mode  <= min_mode;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd_r      <= req.cmd;
          key_r      <= req.key_in;
          res_key    <= '0;
          res_status <= STAT_OK;
        end
      end
      S_CHECK: begin
        if (mode_stale) begin
          hj  <= hj_start;
          lim <= cnt;
        end else if (cmd_r == CMD_INSERT) begin
          if (full) begin
            res_status <= STAT_FULL;
          end else begin
            idx <= IDX_W'(cnt);
            k   <= key_r;
          end
        end else if (cmd_r == CMD_EXTRACT && cnt == '0) begin
          res_status <= STAT_EMPTY;
        end
      end
      S_EXT_LD: begin
        res_key <= rd_data_a;
        k       <= rd_data_b;
        lim     <= cnt - CNT_W'(1);
        idx     <= '0;
      end
      S_HEAP_LD: begin
        k   <= rd_data_a;
        idx <= hj;
      end
      S_DOWN_ISSUE, S_DOWN_EVAL: begin
        if (down_done) begin
          if (rebuilding && hj != '0) hj <= hj - IDX_W'(1);
        end else if (state == S_DOWN_EVAL) begin
          idx <= c_idx;
        end
      end
      S_UP_EVAL: begin
        if (key_wins) idx <= parent;
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.key_out <= res_key;
      rsp.status  <= res_status;
      rsp.count   <= COUNT_W'(cnt);
    end
  end

  // A request moves the sequencer out of idle.
  a_req_starts: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_CHECK)
    else $error("accepted request did not start the sequencer");

  // The held count never exceeds the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("held count beyond capacity");

  // Heap writes stay inside the occupied region.
  a_wr_in_heap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> CNT_W'(wr_addr) < cnt)
    else $error("key store written outside the heap");

  // A result appears only out of the completion state.
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_DONE))
    else $error("result raised outside completion");

  // An empty status always reports an empty queue.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == STAT_EMPTY |-> rsp.count == '0)
    else $error("empty status with keys held");

endmodule

// ----- hdl/min_max_priority_queue.sv -----
// Bounded priority queue of signed keys, kept as a binary heap in one
// synchronous key memory.
// Requests arrive on the req channel (cmd, key_in): insert, extract top or
// clear. Each request yields exactly one transaction on the rsp channel
// carrying the extracted key (zero if none), a status and the held count.
// The min_mode register at address 0 of the APB port selects smallest-first
// (1, reset value) or largest-first (0) order.
// One request is processed at a time. A clear, an unused code, a dropped
// insert or an extract from an empty queue goes straight from the check to
// completion. An insert sifts its key up from the new last slot towards the
// root; an extract takes the root and sifts the last key down from there.
// Each heap level costs one memory read and one compare-and-write.
// The first insert or extract after min_mode changes with more than one key
// held first rebuilds the heap bottom-up, about n/2 sift-downs for n keys.
// Reset empties the queue and sets smallest-first order; no memory clearing
// pass is needed. The result sits in an output register, so the next request
// is taken while it waits; a stalled receiver only holds back the request
// after that.
module min_max_priority_queue
  import pq_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  pq_req_if.sink                req,
  pq_rsp_if.source              rsp
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic                 min_mode;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [IDX_W-1:0]     rd_addr_a, rd_addr_b;
  logic [KEY_WIDTH-1:0] rd_data_a, rd_data_b;

  // Configuration register.
  pq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .min_mode (min_mode)
  );

  // Heap storage.
  pq_key_ram #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Heap sequencer.
  pq_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .min_mode  (min_mode),
    .req       (req),
    .rsp       (rsp),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule

// ----- verif/testbench.sv -----
import pq_pkg::*;

typedef logic signed [DEF_KEY_WIDTH-1:0] key_t;

typedef struct {
  key_t                key;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
} pq_result_t;

// Scoreboard that mirrors the queue contents and the order select, and holds
// the results still owed by the block in arrival order.
class queue_scoreboard;
  key_t       held_keys[$];
  bit         smallest_first;
  pq_result_t awaited[$];
  int         mismatches;
  int         checked;
  int         n_insert;
  int         n_dropped;
  int         n_extract;
  int         n_empty;
  int         n_clear;
  int         n_unused;

  function new();
    smallest_first = MIN_MODE_RESET;
  endfunction

  function void set_order(bit smallest);
    smallest_first = smallest;
  endfunction

  // Work out the result of one accepted request and update the mirror.
  function void note_request(logic [CMD_W-1:0] cmd, key_t key);
    pq_result_t r;
    int         best;
    r.key    = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_INSERT: begin
        n_insert++;
        if (held_keys.size() >= DEF_CAPACITY) begin
          r.status = STAT_FULL;
          n_dropped++;
        end else begin
          held_keys = {held_keys, key};
        end
      end
      CMD_EXTRACT: begin
        n_extract++;
        if (held_keys.size() == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else begin
          best = 0;
          for (int i = 1; i < held_keys.size(); i++) begin
            if (smallest_first ? (held_keys[i] < held_keys[best])
                               : (held_keys[i] > held_keys[best]))
              best = i;
          end
          r.key = held_keys[best];
          held_keys.delete(best);
        end
      end
      CMD_CLEAR: begin
        n_clear++;
        held_keys.delete();
      end
      default: begin
        n_unused++;
      end
    endcase
    r.count = COUNT_W'(held_keys.size());
    awaited = {awaited, r};
  endfunction

  // Compare one result transaction with the oldest awaited result.
  function void check_response(key_t key, logic [STATUS_W-1:0] status,
                               logic [COUNT_W-1:0] count);
    pq_result_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: key_out %0d status %0d count %0d",
               $time, key, status, count);
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (key !== want.key) begin
      mismatches++;
      $display("%0t: key_out mismatch: expected %0d, actual %0d", $time, want.key, key);
    end
    if (status !== want.status) begin
      mismatches++;
      $display("%0t: status mismatch: expected %0d, actual %0d",
               $time, want.status, status);
    end
    if (count !== want.count) begin
      mismatches++;
      $display("%0t: count mismatch: expected %0d, actual %0d", $time, want.count, count);
    end
  endfunction
endclass

module testbench;

  // The block leaves code three unassigned; it must change nothing.
  localparam logic [CMD_W-1:0]      CMD_UNUSED    = 2'd3;
  localparam logic [APB_ADDR_W-1:0] MIN_MODE_ADDR = APB_ADDR_W'(4 * REG_MIN_MODE);
  localparam key_t                  KEY_MAX       = {1'b0, {(DEF_KEY_WIDTH-1){1'b1}}};
  localparam key_t                  KEY_MIN       = {1'b1, {(DEF_KEY_WIDTH-1){1'b0}}};
  localparam int                    DRAIN_CYCLES  = 50;
  localparam int                    LIMIT_CYCLES  = 800000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pq_req_if #(.KEY_WIDTH(DEF_KEY_WIDTH)) req_ch();
  pq_rsp_if #(.KEY_WIDTH(DEF_KEY_WIDTH)) rsp_ch();

  queue_scoreboard sb = new();
  bit              gaps_on = 1'b1;
  int              order_writes;
  int              stall_left;

  min_max_priority_queue dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  always #10 clk = ~clk;

  // Keys lean towards the extremes and a narrow band, so that duplicates occur.
  function automatic key_t random_key();
    case ($urandom_range(0, 9))
      0:       return KEY_MAX;
      1:       return KEY_MIN;
      2:       return key_t'(int'($urandom_range(0, 2)) - 1);
      3, 4, 5: return key_t'(int'($urandom_range(0, 16)) - 8);
      default: return key_t'($urandom);
    endcase
  endfunction

  // Offer one request, with an optional gap first, and note it once accepted.
  task automatic issue_request(logic [CMD_W-1:0] cmd, key_t key);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.cmd    <= cmd;
    req_ch.key_in <= key;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(cmd, key);
  endtask

  // Drop the request valid and wait until every result has been taken.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // Write the order select once the block is idle, then read it back.
  task automatic write_order(bit smallest);
    logic [APB_DATA_W-1:0] readback;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MIN_MODE_ADDR;
    pwdata  <= APB_DATA_W'(smallest);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_order(smallest);
    order_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[0] !== smallest) begin
      sb.mismatches++;
      $display("%0t: min_mode readback mismatch: expected %0d, actual %0d",
               $time, smallest, readback[0]);
    end
  endtask

  // Mixed traffic; the remainder after inserts is mostly extracts.
  task automatic random_traffic(int n, int insert_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct)
        issue_request(CMD_INSERT, random_key());
      else if (r < 96)
        issue_request(CMD_EXTRACT, random_key());
      else if (r < 98)
        issue_request(CMD_CLEAR, random_key());
      else
        issue_request(CMD_UNUSED, random_key());
    end
  endtask

  // Result side: check each transaction and stall the receiver in bursts.
  initial begin
    rsp_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        sb.check_response(rsp_ch.key_out, rsp_ch.status, rsp_ch.count);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.cmd    <= CMD_INSERT;
    req_ch.key_in <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queue, unused code, extremes and duplicates in min order.
    issue_request(CMD_EXTRACT, KEY_MAX);
    issue_request(CMD_CLEAR, KEY_MIN);
    issue_request(CMD_UNUSED, '0);
    issue_request(CMD_INSERT, KEY_MAX);
    issue_request(CMD_INSERT, KEY_MIN);
    issue_request(CMD_INSERT, '0);
    issue_request(CMD_INSERT, -1);
    issue_request(CMD_INSERT, 1);
    issue_request(CMD_INSERT, KEY_MIN);
    issue_request(CMD_UNUSED, KEY_MAX);
    issue_request(CMD_EXTRACT, '0);
    issue_request(CMD_EXTRACT, '0);
    issue_request(CMD_EXTRACT, '0);

    // Switch to max order with keys still held.
    write_order(1'b0);
    issue_request(CMD_INSERT, 5);
    issue_request(CMD_EXTRACT, '0);
    issue_request(CMD_EXTRACT, '0);
    issue_request(CMD_CLEAR, '0);
    issue_request(CMD_EXTRACT, '0);
    issue_request(CMD_INSERT, -5);
    issue_request(CMD_INSERT, key_t'(32'h5555_5555));
    issue_request(CMD_INSERT, key_t'(32'hAAAA_AAAA));
    issue_request(CMD_EXTRACT, '0);
    issue_request(CMD_EXTRACT, '0);
    issue_request(CMD_EXTRACT, '0);
    issue_request(CMD_EXTRACT, '0);

    // Random traffic in each order, the switch made with keys held.
    random_traffic(250, 55);
    write_order(1'b1);
    random_traffic(250, 65);

    // Fill to capacity, overflow, then flip the order on a full queue.
    issue_request(CMD_CLEAR, '0);
    repeat (DEF_CAPACITY + 12) issue_request(CMD_INSERT, random_key());
    write_order(1'b0);
    issue_request(CMD_EXTRACT, '0);
    issue_request(CMD_INSERT, random_key());
    issue_request(CMD_INSERT, random_key());
    random_traffic(130, 30);

    // Last stretch at full rate on both sides.
    gaps_on = 1'b0;
    write_order(1'b1);
    random_traffic(120, 50);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.awaited.size() != 0) begin
      sb.mismatches++;
      $display("%0t: %0d results never arrived", $time, sb.awaited.size());
    end
    $display("Covered %0d inserts (%0d dropped when full), %0d extracts (%0d on empty),",
             sb.n_insert, sb.n_dropped, sb.n_extract, sb.n_empty);
    $display("%0d clears, %0d unused codes; %0d results checked over %0d order writes.",
             sb.n_clear, sb.n_unused, sb.checked, order_writes);
    if (sb.mismatches == 0) begin
      $display("PASS min_max_priority_queue");
    end else begin
      $display("FAIL min_max_priority_queue");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("FAIL min_max_priority_queue");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pq_pkg.sv
hdl/pq_req_if.sv
hdl/pq_rsp_if.sv
hdl/pq_cfg.sv
hdl/pq_key_ram.sv
hdl/pq_ctrl.sv
hdl/min_max_priority_queue.sv
verif/testbench.sv
